### rtl/core/kwo_pkg.sv
// Shared types and constants for the knee waveshaper overdrive unit.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package kwo_pkg;

  // Sample format: signed Q1.14.
  localparam int SAMPLE_W = 16;
  localparam int FRAC_W   = 14;

  // Register field widths.
  localparam int KNEE_W  = 14;
  localparam int LEVEL_W = 15;
  localparam int GAIN_W  = 15;

  // Derived coefficient widths: slopes reach 2^28, the offset reaches -2^28.
  localparam int SLOPE_W  = 29;
  localparam int OFFSET_W = 30;

  // Divider widths: dividend is a 15-bit value shifted up by FRAC_W.
  localparam int DVD_W = LEVEL_W + FRAC_W;
  localparam int DSR_W = KNEE_W;

  // Curve magnitude after shaping, at most just over 1.0.
  localparam int MAG_W = 16;

  localparam logic [LEVEL_W-1:0] FX_ONE = LEVEL_W'(1 << FRAC_W);

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_KNEE_POINT   = 2'd0;
  localparam logic [1:0] REG_KNEE_LEVEL   = 2'd1;
  localparam logic [1:0] REG_DRY_FRACTION = 2'd2;
  localparam logic [1:0] REG_OUTPUT_GAIN  = 2'd3;

  // Coefficients handed from the register block to the datapath.
  typedef struct packed {
    logic [KNEE_W-1:0]          knee;
    logic [SLOPE_W-1:0]         slope_lo;
    logic [SLOPE_W-1:0]         slope_hi;
    logic signed [OFFSET_W-1:0] offset;
    logic [LEVEL_W-1:0]         dry;
    logic [LEVEL_W-1:0]         wet;
    logic [GAIN_W-1:0]          gain;
  } kwo_coef_t;

  // Beat passed from the shaper to the mixer.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x;
    logic signed [MAG_W:0]      shaped;
  } kwo_shp_t;

endpackage

### rtl/core/kwo_div.sv
// Restoring divider, one quotient bit per cycle, for coefficient setup.
// Depends on kwo_pkg for operand widths.
`timescale 1ns / 1ps

module kwo_div
  import kwo_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DSR_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(DVD_W - 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DVD_W-1:0] dvd;
  logic [DSR_W-1:0] dsr;
  logic [DSR_W-1:0] rem;

  logic [DSR_W:0]   rem_sh;
  logic             ge;
  logic [DSR_W:0]   rem_sub;
  logic [DSR_W-1:0] rem_next;

  // One restoring step: shift in the next dividend bit and try a subtract.
  always_comb begin
    rem_sh   = {rem, dvd[DVD_W-1]};
    ge       = rem_sh >= {1'b0, dsr};
    rem_sub  = rem_sh - {1'b0, dsr};
    rem_next = ge ? rem_sub[DSR_W-1:0] : rem_sh[DSR_W-1:0];
  end

  // Control: busy until every quotient bit is in, done pulses once the quotient is whole.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (start) begin
      dvd      <= dividend;
      dsr      <= divisor;
      rem      <= '0;
      quotient <= '0;
    end else if (busy) begin
      dvd      <= {dvd[DVD_W-2:0], 1'b0};
      rem      <= rem_next;
      quotient <= {quotient[DVD_W-2:0], ge};
    end
  end

endmodule

### rtl/core/kwo_cfg.sv
// Register file with APB-style access and the coefficient setup sequencer.
// Depends on kwo_pkg and kwo_div.
`timescale 1ns / 1ps

module kwo_cfg
  import kwo_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic        busy,
  output kwo_coef_t   coef
);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_LO_GO   = 7'b0000010,
    S_LO_WAIT = 7'b0000100,
    S_HI_GO   = 7'b0001000,
    S_HI_WAIT = 7'b0010000,
    S_MUL     = 7'b0100000,
    S_OFF     = 7'b1000000
  } seq_state_t;

  localparam int PROD_W = SLOPE_W + KNEE_W;

  seq_state_t state;
  seq_state_t state_next;

  logic [KNEE_W-1:0]  knee_point;
  logic [LEVEL_W-1:0] knee_level;
  logic [LEVEL_W-1:0] dry_fraction;
  logic [GAIN_W-1:0]  output_gain;

  logic [SLOPE_W-1:0]         slope_lo;
  logic [SLOPE_W-1:0]         slope_hi;
  logic signed [OFFSET_W-1:0] offset;
  logic [PROD_W-1:0]          knee_prod;

  logic [KNEE_W-1:0]  knee_eff;
  logic [LEVEL_W-1:0] level_eff;
  logic [LEVEL_W-1:0] dry_eff;
  logic [LEVEL_W-1:0] level_rest;
  logic [LEVEL_W-1:0] knee_rest;

  logic             wr_fire;
  logic [1:0]       wr_index;
  logic             div_start;
  logic [DVD_W-1:0] div_dividend;
  logic [DSR_W-1:0] div_divisor;
  logic             div_done;
  logic [DVD_W-1:0] div_quot;

  assign pready   = 1'b1;
  assign wr_fire  = psel && penable && pwrite && pready;
  assign wr_index = paddr[3:2];

  // Register writes, masked to each field's width.
  always_ff @(posedge clk) begin
    if (rst) begin
      knee_point   <= KNEE_W'(8192);
      knee_level   <= LEVEL_W'(8192);
      dry_fraction <= LEVEL_W'(8192);
      output_gain  <= GAIN_W'(16384);
    end else if (wr_fire) begin
      case (wr_index)
        REG_KNEE_POINT:   knee_point   <= pwdata[KNEE_W-1:0];
        REG_KNEE_LEVEL:   knee_level   <= pwdata[LEVEL_W-1:0];
        REG_DRY_FRACTION: dry_fraction <= pwdata[LEVEL_W-1:0];
        REG_OUTPUT_GAIN:  output_gain  <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back of the stored register values.
  always_comb begin
    case (paddr[3:2])
      REG_KNEE_POINT:   prdata = {{(32-KNEE_W){1'b0}}, knee_point};
      REG_KNEE_LEVEL:   prdata = {{(32-LEVEL_W){1'b0}}, knee_level};
      REG_DRY_FRACTION: prdata = {{(32-LEVEL_W){1'b0}}, dry_fraction};
      REG_OUTPUT_GAIN:  prdata = {{(32-GAIN_W){1'b0}}, output_gain};
      default:          prdata = '0;
    endcase
  end

  // Effective values: knee kept at least one, level and dry capped at 1.0.
  always_comb begin
    knee_eff   = (knee_point == '0) ? KNEE_W'(1) : knee_point;
    level_eff  = (knee_level > FX_ONE) ? FX_ONE : knee_level;
    dry_eff    = (dry_fraction > FX_ONE) ? FX_ONE : dry_fraction;
    level_rest = FX_ONE - level_eff;
    knee_rest  = FX_ONE - {1'b0, knee_eff};
  end

  // Sequencer: lower slope, upper slope, then the upper line's offset.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:    if (wr_fire) state_next = S_LO_GO;
      S_LO_GO:   state_next = S_LO_WAIT;
      S_LO_WAIT: if (div_done) state_next = S_HI_GO;
      S_HI_GO:   state_next = S_HI_WAIT;
      S_HI_WAIT: if (div_done) state_next = S_MUL;
      S_MUL:     state_next = S_OFF;
      S_OFF:     state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
    // A write during an update starts the sequence over with the new values.
    if (wr_fire) state_next = S_LO_GO;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Divider operands for the two slopes.
  always_comb begin
    div_start = (state == S_LO_GO) || (state == S_HI_GO);
    if (state == S_HI_GO) begin
      div_dividend = {level_rest, {FRAC_W{1'b0}}};
      div_divisor  = knee_rest[DSR_W-1:0];
    end else begin
      div_dividend = {level_eff, {FRAC_W{1'b0}}};
      div_divisor  = knee_eff;
    end
  end

  kwo_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  // Coefficient registers; reset values match the reset register set.
  always_ff @(posedge clk) begin
    if (rst) begin
      slope_lo <= SLOPE_W'(16384);
      slope_hi <= SLOPE_W'(16384);
      offset   <= '0;
    end else begin
      if (state == S_LO_WAIT && div_done) slope_lo <= div_quot[SLOPE_W-1:0];
      if (state == S_HI_WAIT && div_done) slope_hi <= div_quot[SLOPE_W-1:0];
      if (state == S_OFF) begin
        offset <= $signed({{(OFFSET_W-LEVEL_W){1'b0}}, level_eff})
                - $signed({1'b0, knee_prod[PROD_W-1:FRAC_W]});
      end
    end
  end

  // Product of the upper slope and the knee, registered before the subtract.
  always_ff @(posedge clk) begin
    if (state == S_MUL) knee_prod <= PROD_W'(slope_hi) * PROD_W'(knee_eff);
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    coef.knee     = knee_eff;
    coef.slope_lo = slope_lo;
    coef.slope_hi = slope_hi;
    coef.offset   = offset;
    coef.dry      = dry_eff;
    coef.wet      = FX_ONE - dry_eff;
    coef.gain     = output_gain;
  end

endmodule

### rtl/core/kwo_shaper.sv
// Three-stage transfer curve: magnitude and region, slope product, offset and sign.
// Depends on kwo_pkg for the coefficient and beat types.
`timescale 1ns / 1ps

module kwo_shaper
  import kwo_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  kwo_coef_t                  coef,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_x,
  output logic                       out_valid,
  input  logic                       out_ready,
  output kwo_shp_t                   out_beat
);

  localparam int PROD_W = LEVEL_W + SLOPE_W;
  localparam int T_W    = PROD_W - FRAC_W;

  logic v1, v2, v3;
  logic ld1, ld2, ld3;

  // Stage 1 registers.
  logic signed [SAMPLE_W-1:0] x1;
  logic [LEVEL_W-1:0]         mag1;
  logic [SLOPE_W-1:0]         slope1;
  logic                       clamp1, above1;

  // Stage 2 registers.
  logic signed [SAMPLE_W-1:0] x2;
  logic [PROD_W-1:0]          prod2;
  logic                       clamp2, above2;

  // Stage 3 registers.
  logic signed [SAMPLE_W-1:0] x3;
  logic signed [MAG_W:0]      shaped3;

  logic signed [SAMPLE_W:0] x_ext;
  logic [SAMPLE_W:0]        mag_full;
  logic [T_W-1:0]           t2;
  logic signed [T_W:0]      line2;
  logic [MAG_W-1:0]         mag_sh;

  // A stage loads when it is empty or its content moves on.
  assign ld3      = !v3 || out_ready;
  assign ld2      = !v2 || ld3;
  assign ld1      = !v1 || ld2;
  assign in_ready = ld1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (ld1) v1 <= in_valid;
      if (ld2) v2 <= v1;
      if (ld3) v3 <= v2;
    end
  end

  // Stage 1: magnitude, clamp above 1.0 and knee region.
  always_comb begin
    x_ext    = {in_x[SAMPLE_W-1], in_x};
    mag_full = in_x[SAMPLE_W-1] ? (~x_ext + (SAMPLE_W+1)'(1)) : x_ext;
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      x1     <= in_x;
      mag1   <= mag_full[LEVEL_W-1:0];
      clamp1 <= mag_full > {{(SAMPLE_W+1-LEVEL_W){1'b0}}, FX_ONE};
      above1 <= mag_full > {{(SAMPLE_W+1-KNEE_W){1'b0}}, coef.knee};
      slope1 <= (mag_full > {{(SAMPLE_W+1-KNEE_W){1'b0}}, coef.knee})
                ? coef.slope_hi : coef.slope_lo;
    end
  end

  // Stage 2: magnitude times the selected slope.
  always_ff @(posedge clk) begin
    if (ld2) begin
      x2     <= x1;
      prod2  <= PROD_W'(mag1) * PROD_W'(slope1);
      clamp2 <= clamp1;
      above2 <= above1;
    end
  end

  // Stage 3: drop the fraction, add the upper offset, restore the sign.
  always_comb begin
    t2    = prod2[PROD_W-1:FRAC_W];
    line2 = $signed({1'b0, t2}) + (T_W+1)'(coef.offset);
    if (clamp2) begin
      mag_sh = {1'b0, FX_ONE};
    end else if (above2) begin
      mag_sh = line2[MAG_W-1:0];
    end else begin
      mag_sh = t2[MAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ld3) begin
      x3      <= x2;
      shaped3 <= x2[SAMPLE_W-1] ? -$signed({1'b0, mag_sh}) : $signed({1'b0, mag_sh});
    end
  end

  assign out_valid       = v3;
  assign out_beat.x      = x3;
  assign out_beat.shaped = shaped3;

endmodule

### rtl/core/kwo_mix.sv
// Four-stage dry/wet mix, output gain and saturation into the output register.
// Depends on kwo_pkg for the coefficient and beat types.
`timescale 1ns / 1ps

module kwo_mix
  import kwo_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  kwo_coef_t                  coef,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  kwo_shp_t                   in_beat,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_y
);

  localparam int DP_W  = LEVEL_W + 1 + SAMPLE_W;
  localparam int WP_W  = LEVEL_W + 1 + MAG_W + 1;
  localparam int MIX_W = SAMPLE_W + 2;
  localparam int YP_W  = GAIN_W + 1 + MIX_W;
  localparam int Y_W   = YP_W - FRAC_W;

  localparam logic signed [Y_W-1:0] Y_MAX = Y_W'((1 << (SAMPLE_W - 1)) - 1);
  localparam logic signed [Y_W-1:0] Y_MIN = -Y_MAX - Y_W'(1);

  logic v1, v2, v3, v4;
  logic ld1, ld2, ld3, ld4;

  logic signed [DP_W-1:0]     dry_prod1;
  logic signed [WP_W-1:0]     wet_prod1;
  logic signed [MIX_W-1:0]    mix2;
  logic signed [YP_W-1:0]     y_prod3;
  logic signed [SAMPLE_W-1:0] y4;

  logic signed [DP_W-FRAC_W-1:0] dry_term;
  logic signed [WP_W-FRAC_W-1:0] wet_term;
  logic signed [Y_W-1:0]         y_full;

  assign ld4      = !v4 || out_ready;
  assign ld3      = !v3 || ld4;
  assign ld2      = !v2 || ld3;
  assign ld1      = !v1 || ld2;
  assign in_ready = ld1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (ld1) v1 <= in_valid;
      if (ld2) v2 <= v1;
      if (ld3) v3 <= v2;
      if (ld4) v4 <= v3;
    end
  end

  // Stage 1: dry and wet products side by side.
  always_ff @(posedge clk) begin
    if (ld1) begin
      dry_prod1 <= DP_W'($signed({1'b0, coef.dry})) * DP_W'(in_beat.x);
      wet_prod1 <= WP_W'($signed({1'b0, coef.wet})) * WP_W'(in_beat.shaped);
    end
  end

  // Stage 2: floor both products to Q.14 and sum them.
  always_comb begin
    dry_term = (DP_W-FRAC_W)'(dry_prod1 >>> FRAC_W);
    wet_term = (WP_W-FRAC_W)'(wet_prod1 >>> FRAC_W);
  end

  always_ff @(posedge clk) begin
    if (ld2) mix2 <= MIX_W'(dry_term) + MIX_W'(wet_term);
  end

  // Stage 3: output gain.
  always_ff @(posedge clk) begin
    if (ld3) y_prod3 <= YP_W'($signed({1'b0, coef.gain})) * YP_W'(mix2);
  end

  // Stage 4: floor, then saturate to the sample range.
  assign y_full = Y_W'(y_prod3 >>> FRAC_W);

  always_ff @(posedge clk) begin
    if (ld4) begin
      if (y_full > Y_MAX) begin
        y4 <= Y_MAX[SAMPLE_W-1:0];
      end else if (y_full < Y_MIN) begin
        y4 <= Y_MIN[SAMPLE_W-1:0];
      end else begin
        y4 <= y_full[SAMPLE_W-1:0];
      end
    end
  end

  assign out_valid = v4;
  assign out_y     = y4;

endmodule

### rtl/core/knee_waveshaper_overdrive_unit.sv
// Top level of the knee waveshaper overdrive: stream ports, register port, datapath.
// Depends on kwo_pkg, kwo_cfg, kwo_shaper and kwo_mix.
//
//   channel   direction   handshake                  payload
//   s_*       in          s_tvalid / s_tready        s_tdata[15:0] = sample_in
//   m_*       out         m_tvalid / m_tready        m_tdata[15:0] = sample_out
//   apb       in          psel, penable, pready      paddr[3:2] = register, pwdata
//
// One sample per cycle is accepted unless the output stalls or a coefficient update runs.
// After a register write the input is held off until the update for the last write ends,
// also when several come close together, while both slopes are recomputed by the
// one-bit-per-cycle divider and the offset is formed.
// Reset is synchronous and loads the register defaults with their coefficients ready.
// Each pipeline stage holds its beat under a stall, and empty stages keep filling.
`timescale 1ns / 1ps

module knee_waveshaper_overdrive_unit
  import kwo_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] sample_in
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] sample_out
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  kwo_coef_t coef;
  kwo_shp_t  shp_beat;
  logic      cfg_busy;
  logic      shp_in_ready;
  logic      shp_valid;
  logic      mix_ready;

  logic signed [SAMPLE_W-1:0] y;

  kwo_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .busy    (cfg_busy),
    .coef    (coef)
  );

  // Input is held off while the coefficients are being rebuilt.
  assign s_tready = shp_in_ready && !cfg_busy;

  kwo_shaper u_shaper (
    .clk       (clk),
    .rst       (rst),
    .coef      (coef),
    .in_valid  (s_tvalid && !cfg_busy),
    .in_ready  (shp_in_ready),
    .in_x      ($signed(s_tdata)),
    .out_valid (shp_valid),
    .out_ready (mix_ready),
    .out_beat  (shp_beat)
  );

  kwo_mix u_mix (
    .clk       (clk),
    .rst       (rst),
    .coef      (coef),
    .in_valid  (shp_valid),
    .in_ready  (mix_ready),
    .in_beat   (shp_beat),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_y     (y)
  );

  assign m_tdata = y;

endmodule

### tb/knee_waveshaper_overdrive_unit_checker.sv
// Checker for the knee waveshaper overdrive unit: follows register writes on the APB port,
// predicts every output sample from the accepted input beats and compares them in order.
// Depends on kwo_pkg for field widths and register indexes.
`timescale 1ns / 1ps

module knee_waveshaper_overdrive_unit_checker
  import kwo_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  input  logic                s_tready,
  input  logic [SAMPLE_W-1:0] s_tdata,
  input  logic                m_tvalid,
  input  logic                m_tready,
  input  logic [SAMPLE_W-1:0] m_tdata,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic                pready,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output int                  pending,
  output int                  errors
);

  localparam longint UNITY  = longint'(1) << FRAC_W;
  localparam longint SAT_HI = (longint'(1) << (SAMPLE_W - 1)) - 1;
  localparam longint SAT_LO = -SAT_HI - 1;

  // Register image as the block should hold it, masked to the field widths.
  typedef struct {
    logic [KNEE_W-1:0]  knee;
    logic [LEVEL_W-1:0] level;
    logic [LEVEL_W-1:0] dry;
    logic [GAIN_W-1:0]  gain;
  } panel_t;

  panel_t panel;
  longint slope_lo;
  longint slope_hi;
  longint offset_hi;

  logic [SAMPLE_W-1:0] expected_samples[$];
  int error_count = 0;
  int beats_out = 0;

  // Q.14 product, rounded toward minus infinity.
  function automatic longint q14_mul(longint a, longint b);
    return (a * b) >>> FRAC_W;
  endfunction

  // A knee of zero acts as the smallest knee.
  function automatic longint knee_eff();
    longint k;
    k = longint'(panel.knee);
    if (k < 1) k = 1;
    if (k > UNITY - 1) k = UNITY - 1;
    return k;
  endfunction

  function automatic longint level_eff();
    longint l;
    l = longint'(panel.level);
    if (l > UNITY) l = UNITY;
    return l;
  endfunction

  // Both line segments follow from knee and level after every register write.
  function automatic void recompute_curve();
    longint k;
    longint l;
    k = knee_eff();
    l = level_eff();
    slope_lo  = (l <<< FRAC_W) / k;
    slope_hi  = ((UNITY - l) <<< FRAC_W) / (UNITY - k);
    offset_hi = l - q14_mul(slope_hi, k);
  endfunction

  // Shape, mix with the dry signal, apply the volume and saturate.
  function automatic logic [SAMPLE_W-1:0] overdrive_sample(logic [SAMPLE_W-1:0] raw);
    longint x;
    longint m;
    longint shaped;
    longint dry;
    longint mix;
    longint y;
    x = longint'($signed(raw));
    m = (x < 0) ? -x : x;
    if (m > UNITY)
      shaped = UNITY;
    else if (m > knee_eff())
      shaped = q14_mul(m, slope_hi) + offset_hi;
    else
      shaped = q14_mul(m, slope_lo);
    if (x < 0) shaped = -shaped;
    dry = longint'(panel.dry);
    if (dry > UNITY) dry = UNITY;
    mix = q14_mul(dry, x) + q14_mul(UNITY - dry, shaped);
    y = q14_mul(longint'(panel.gain), mix);
    if (y > SAT_HI) y = SAT_HI;
    if (y < SAT_LO) y = SAT_LO;
    return y[SAMPLE_W-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    if (error_count < 40) $display("[%0t] checker: %s", $time, msg);
    error_count++;
  endtask

  always @(posedge clk) begin : watch
    logic [SAMPLE_W-1:0] want;
    if (rst) begin
      panel.knee  = KNEE_W'(8192);
      panel.level = LEVEL_W'(8192);
      panel.dry   = LEVEL_W'(8192);
      panel.gain  = GAIN_W'(16384);
      recompute_curve();
      expected_samples.delete();
    end else begin
      // Register writes land on the access cycle.
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_KNEE_POINT:   panel.knee  = pwdata[KNEE_W-1:0];
          REG_KNEE_LEVEL:   panel.level = pwdata[LEVEL_W-1:0];
          REG_DRY_FRACTION: panel.dry   = pwdata[LEVEL_W-1:0];
          REG_OUTPUT_GAIN:  panel.gain  = pwdata[GAIN_W-1:0];
          default: ;
        endcase
        recompute_curve();
      end
      // Each output beat is matched against the oldest prediction.
      if (m_tvalid && m_tready) begin
        if (expected_samples.size() == 0) begin
          report_mismatch($sformatf("output beat %0d (%0d) with nothing expected",
                                    beats_out, $signed(m_tdata)));
        end else begin
          want = expected_samples.pop_front();
          if (m_tdata !== want)
            report_mismatch($sformatf("beat %0d sample_out got %0d, expected %0d",
                                      beats_out, $signed(m_tdata), $signed(want)));
        end
        beats_out++;
      end
      if (s_tvalid && s_tready) expected_samples.push_back(overdrive_sample(s_tdata));
    end
    pending <= expected_samples.size();
    errors  <= error_count;
  end

endmodule

### tb/knee_waveshaper_overdrive_unit_tb.sv
// Testbench top for the knee waveshaper overdrive unit: clock, reset, register writes,
// sample stimulus with random gaps and output stalls, and the final verdict.
// Depends on kwo_pkg, the unit itself and knee_waveshaper_overdrive_unit_checker.
`timescale 1ns / 1ps

module knee_waveshaper_overdrive_unit_tb;
  import kwo_pkg::*;

  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_SAMPLES = 125;
  localparam int HOLD_CYCLES = 400;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int pending;
  int errors;

  // Asks the output side for one long hold while input keeps coming.
  logic flood = 1'b0;
  // Sender runs without gaps while set.
  bit steady = 1'b0;
  int cur_knee = 8192;

  logic [15:0] corner_samples [12] = '{16'h0000, 16'h0001, 16'hFFFF, 16'h4000,
                                       16'hC000, 16'h7FFF, 16'h8000, 16'h2000,
                                       16'h2001, 16'hDFFF, 16'h4001, 16'hBFFF};
  logic [15:0] steep_samples [6] = '{16'h0001, 16'h0002, 16'hFFFE, 16'h4000,
                                     16'h4001, 16'h8000};
  logic [15:0] flat_samples [6]  = '{16'h3FFF, 16'h4000, 16'hC001, 16'h0064,
                                     16'hFF9C, 16'h7FFF};

  always #1 clk = ~clk;

  knee_waveshaper_overdrive_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  knee_waveshaper_overdrive_unit_checker u_curve_check (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .pready   (pready),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .pending  (pending),
    .errors   (errors)
  );

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Samples cluster around the knee, around 1.0 and at the corners.
  function automatic logic [15:0] pick_sample(int knee_now);
    int r;
    int v;
    logic [15:0] any;
    r = $urandom_range(0, 9);
    any = 16'($urandom);
    case (r)
      0, 1, 2, 3: v = $signed(any);
      4: v = knee_now + int'($urandom_range(0, 6)) - 3;
      5: v = 16384 + int'($urandom_range(0, 4)) - 2;
      6: begin
        case ($urandom_range(0, 4))
          0: v = -32768;
          1: v = 32767;
          2: v = 0;
          3: v = -1;
          default: v = 1;
        endcase
      end
      default: v = int'($urandom_range(0, 32768)) - 16384;
    endcase
    if ((r == 4 || r == 5) && $urandom_range(0, 1)) v = -v;
    return v[15:0];
  endfunction

  function automatic logic [14:0] pick_reg(int lo, int hi, int field_max);
    case ($urandom_range(0, 9))
      0: return 15'(lo);
      1: return 15'(hi);
      2: return 15'(field_max);
      default: return 15'($urandom_range(lo, hi));
    endcase
  endfunction

  // Setup cycle, access cycle, then the bus goes idle; upper data bits are junk half the time.
  task automatic write_reg(input logic [1:0] idx, input logic [14:0] value, input int width);
    logic [31:0] word;
    word = {17'd0, value};
    if ($urandom_range(0, 1)) word = (($urandom >> width) << width) | word;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_panel(input logic [14:0] knee, input logic [14:0] level,
                             input logic [14:0] dry, input logic [14:0] gain);
    write_reg(REG_KNEE_POINT, knee, KNEE_W);
    write_reg(REG_KNEE_LEVEL, level, LEVEL_W);
    write_reg(REG_DRY_FRACTION, dry, LEVEL_W);
    write_reg(REG_OUTPUT_GAIN, gain, GAIN_W);
    cur_knee = (knee[KNEE_W-1:0] == 0) ? 1 : int'(knee[KNEE_W-1:0]);
  endtask

  task automatic send_sample(input logic [15:0] value);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Drop valid after the last beat, wait until every result is back, then let the pipe empty.
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Output side: ready runs and stalls of random length, plus one long hold on request.
  initial begin : sink
    bit held;
    int run;
    int stall;
    held = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (flood && !held) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 20);
        m_tready <= 1'b1;
        // A pending hold request cuts the ready run short.
        for (int c = 0; c < run; c++) begin
          if (flood && !held) break;
          @(posedge clk);
        end
        stall = pick_gap();
        if (stall > 0) begin
          m_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    logic [14:0] knee;
    logic [14:0] level;
    logic [14:0] dry;
    logic [14:0] gain;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset values: corners of the sample range and both sides of the knee.
    foreach (corner_samples[i]) send_sample(corner_samples[i]);
    settle();

    // Knee of zero, level above one and full gain.
    apply_panel(15'd0, 15'd32767, 15'd0, 15'd32767);
    foreach (steep_samples[i]) send_sample(steep_samples[i]);
    settle();

    // Highest knee, zero level, dry share above one.
    apply_panel(15'd16383, 15'd0, 15'd32767, 15'd16384);
    foreach (flat_samples[i]) send_sample(flat_samples[i]);
    settle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      knee  = pick_reg(1, 16383, 16383);
      level = pick_reg(0, 16384, 32767);
      dry   = pick_reg(0, 16384, 32767);
      gain  = pick_reg(0, 32767, 32767);
      if (p == 1) begin
        knee  = 15'd1;
        level = 15'd16384;
        dry   = 15'd0;
        gain  = 15'd32767;
      end else if (p == 2) begin
        knee  = 15'd16383;
        level = 15'd0;
        dry   = 15'd16384;
        gain  = 15'd0;
      end
      apply_panel(knee, level, dry, gain);
      steady = ($urandom_range(0, 3) == 0);
      if (p == 0) begin
        // Back-to-back input against a long output hold fills the pipeline.
        steady = 1'b1;
        flood <= 1'b1;
      end
      for (int i = 0; i < PHASE_SAMPLES; i++) begin
        if (p == 0 && i == 80) begin
          steady = 1'b0;
          flood <= 1'b0;
        end
        send_sample(pick_sample(cur_knee));
      end
      settle();
    end

    if (errors == 0 && pending == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

### knee_waveshaper_overdrive_unit.f
rtl/core/kwo_pkg.sv
rtl/core/kwo_div.sv
rtl/core/kwo_cfg.sv
rtl/core/kwo_shaper.sv
rtl/core/kwo_mix.sv
rtl/core/knee_waveshaper_overdrive_unit.sv
tb/knee_waveshaper_overdrive_unit_checker.sv
tb/knee_waveshaper_overdrive_unit_tb.sv
